### sv/tfn_pkg.sv
// Shared widths, constants and types for the triangle flat normal pipeline.
`default_nettype none
package tfn_pkg;
   localparam int CoordBitsDef = 16;
   localparam int IndexBitsDef = 16;
   localparam int NormFracDef  = 14;
   localparam int FieldW       = 16;
   localparam int IdxW         = 48;
   localparam int MagW         = 31;
   localparam int SumW         = 64;
   localparam int RootW        = 32;
   localparam int RemW         = 36;
   localparam int DivRemW      = 34;

   typedef logic [2:0][MagW-1:0] mag_type;

   typedef struct packed {
      logic [2:0]      neg;
      logic            degen;
      logic [IdxW-1:0] idx;
      logic            last;
   } side_type;
endpackage
`default_nettype wire

### sv/tfn_cross.sv
// Front stages: edges, cross product, magnitude scaling and sum of squares.
`default_nettype none
module tfn_cross #(
   parameter int CB = tfn_pkg::CoordBitsDef
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           advance,
   input  wire logic                           in_valid,
   input  wire logic [8:0][tfn_pkg::FieldW-1:0] in_p,
   input  wire tfn_pkg::side_type              in_side,
   output logic                                out_valid,
   output logic [tfn_pkg::SumW-1:0]            out_s,
   output tfn_pkg::mag_type                    out_m,
   output tfn_pkg::side_type                   out_side
);
   localparam int EW  = CB + 1;
   localparam int PW  = 2 * EW;
   localparam int CW  = PW + 1;
   localparam int MW  = CW - 1;
   localparam int XW  = (CB > tfn_pkg::FieldW) ? CB : tfn_pkg::FieldW;
   localparam int XMW = (MW > tfn_pkg::MagW) ? MW : tfn_pkg::MagW;
   localparam int SHW = $clog2(MW);
   localparam int SQW = 2 * tfn_pkg::MagW;

   logic [5:0]             valid_ff;
   tfn_pkg::side_type      side_ff [6];

   logic signed [CB-1:0]   p_val [9];
   logic [XW-1:0]          p_ext [9];
   logic signed [EW-1:0]   e1_in [3], e2_in [3], e1_ff [3], e2_ff [3];
   logic signed [PW-1:0]   pr_in [6], pr_ff [6];
   logic signed [CW-1:0]   c_val [3], c_abs [3];
   logic [MW-1:0]          mag_in [3], mag_ff [3];
   logic [2:0]             neg_in;
   logic [MW-1:0]          mor;
   logic [SHW-1:0]         hi, sh;
   logic [XMW-1:0]         shifted [3];
   tfn_pkg::mag_type       m4_in, m4_ff, m5_ff, m6_ff;
   logic [SQW-1:0]         sq_in [3], sq_ff [3];
   logic [tfn_pkg::SumW-1:0] s_in, s_ff;
   tfn_pkg::side_type      side3_in, side4_in;

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         p_ext[i] = XW'(in_p[i]);
         p_val[i] = signed'(p_ext[i][CB-1:0]);
      end
      for (int k = 0; k < 3; k++) begin
         e1_in[k] = EW'(p_val[3+k]) - EW'(p_val[k]);
         e2_in[k] = EW'(p_val[6+k]) - EW'(p_val[k]);
      end
   end

   always_comb begin
      pr_in[0] = e1_ff[1] * e2_ff[2];
      pr_in[1] = e1_ff[2] * e2_ff[1];
      pr_in[2] = e1_ff[2] * e2_ff[0];
      pr_in[3] = e1_ff[0] * e2_ff[2];
      pr_in[4] = e1_ff[0] * e2_ff[1];
      pr_in[5] = e1_ff[1] * e2_ff[0];
   end

   always_comb begin
      side3_in = side_ff[1];
      for (int k = 0; k < 3; k++) begin
         c_val[k]  = CW'(pr_ff[2*k]) - CW'(pr_ff[2*k+1]);
         c_abs[k]  = c_val[k][CW-1] ? -c_val[k] : c_val[k];
         mag_in[k] = c_abs[k][MW-1:0];
         neg_in[k] = c_val[k][CW-1];
      end
      side3_in.neg = neg_in;
   end

   // common right shift that brings the largest magnitude below 2^31
   always_comb begin
      mor = mag_ff[0] | mag_ff[1] | mag_ff[2];
      hi  = '0;
      for (int i = 0; i < MW; i++) begin
         if (mor[i]) begin
            hi = SHW'(i);
         end
      end
      sh = (hi > SHW'(30)) ? hi - SHW'(30) : '0;
      for (int k = 0; k < 3; k++) begin
         shifted[k] = XMW'(mag_ff[k]) >> sh;
         m4_in[k]   = shifted[k][tfn_pkg::MagW-1:0];
      end
      side4_in       = side_ff[2];
      side4_in.degen = (mor == '0);
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq_in[k] = SQW'(m4_ff[k]) * SQW'(m4_ff[k]);
      end
      s_in = tfn_pkg::SumW'(sq_ff[0]) + tfn_pkg::SumW'(sq_ff[1])
           + tfn_pkg::SumW'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= in_side;
         side_ff[1] <= side_ff[0];
         side_ff[2] <= side3_in;
         side_ff[3] <= side4_in;
         side_ff[4] <= side_ff[3];
         side_ff[5] <= side_ff[4];
         e1_ff      <= e1_in;
         e2_ff      <= e2_in;
         pr_ff      <= pr_in;
         mag_ff     <= mag_in;
         m4_ff      <= m4_in;
         m5_ff      <= m4_ff;
         m6_ff      <= m5_ff;
         sq_ff      <= sq_in;
         s_ff       <= s_in;
      end
   end

   assign out_valid = valid_ff[5];
   assign out_s     = s_ff;
   assign out_m     = m6_ff;
   assign out_side  = side_ff[5];
endmodule
`default_nettype wire

### sv/tfn_sqrt_cell.sv
// One cell of the square root row: resolves one root bit per stage.
`default_nettype none
module tfn_sqrt_cell (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         advance,
   input  wire logic                         in_valid,
   input  wire logic [tfn_pkg::SumW-1:0]     in_s,
   input  wire logic [tfn_pkg::RemW-1:0]     in_rem,
   input  wire logic [tfn_pkg::RootW-1:0]    in_root,
   input  wire tfn_pkg::mag_type             in_m,
   input  wire tfn_pkg::side_type            in_side,
   output logic                              out_valid,
   output logic [tfn_pkg::SumW-1:0]          out_s,
   output logic [tfn_pkg::RemW-1:0]          out_rem,
   output logic [tfn_pkg::RootW-1:0]         out_root,
   output tfn_pkg::mag_type                  out_m,
   output tfn_pkg::side_type                 out_side
);
   logic                           valid_ff;
   logic [tfn_pkg::SumW-1:0]       s_ff, s_in;
   logic [tfn_pkg::RemW-1:0]       rem_ff, rem_in, rem_x, trial;
   logic [tfn_pkg::RootW-1:0]      root_ff, root_in;
   tfn_pkg::mag_type               m_ff;
   tfn_pkg::side_type              side_ff;
   logic                           ge;

   // bring down the next two radicand bits and try root*4+1
   always_comb begin
      rem_x   = {in_rem[tfn_pkg::RemW-3:0], in_s[tfn_pkg::SumW-1 -: 2]};
      trial   = tfn_pkg::RemW'({in_root, 2'b01});
      ge      = (rem_x >= trial);
      rem_in  = ge ? rem_x - trial : rem_x;
      root_in = {in_root[tfn_pkg::RootW-2:0], ge};
      s_in    = {in_s[tfn_pkg::SumW-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s_ff    <= s_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         m_ff    <= in_m;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_s     = s_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_m     = m_ff;
   assign out_side  = side_ff;
endmodule
`default_nettype wire

### sv/tfn_div_cell.sv
// One cell of the divider row: one quotient bit for each of the three lanes.
`default_nettype none
module tfn_div_cell #(
   parameter int QW = tfn_pkg::NormFracDef + 1
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               advance,
   input  wire logic                               in_valid,
   input  wire logic [tfn_pkg::RootW-1:0]          in_len,
   input  wire logic [2:0][tfn_pkg::DivRemW-1:0]   in_r,
   input  wire logic [2:0][QW-1:0]                 in_q,
   input  wire tfn_pkg::side_type                  in_side,
   output logic                                    out_valid,
   output logic [tfn_pkg::RootW-1:0]               out_len,
   output logic [2:0][tfn_pkg::DivRemW-1:0]        out_r,
   output logic [2:0][QW-1:0]                      out_q,
   output tfn_pkg::side_type                       out_side
);
   logic                                  valid_ff;
   logic [tfn_pkg::RootW-1:0]             len_ff;
   logic [2:0][tfn_pkg::DivRemW-1:0]      r_ff, r_in;
   logic [2:0][QW-1:0]                    q_ff, q_in;
   tfn_pkg::side_type                     side_ff;
   logic [tfn_pkg::DivRemW-1:0]           len_x, t [3];
   logic [2:0]                            ge;

   always_comb begin
      len_x = tfn_pkg::DivRemW'(in_len);
      for (int k = 0; k < 3; k++) begin
         ge[k]   = (in_r[k] >= len_x);
         t[k]    = ge[k] ? in_r[k] - len_x : in_r[k];
         r_in[k] = {t[k][tfn_pkg::DivRemW-2:0], 1'b0};
         q_in[k] = {in_q[k][QW-2:0], ge[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         len_ff  <= in_len;
         r_ff    <= r_in;
         q_ff    <= q_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_len   = len_ff;
   assign out_r     = r_ff;
   assign out_q     = q_ff;
   assign out_side  = side_ff;
endmodule
`default_nettype wire

### sv/triangle_flat_normal.sv
// Top level: flat face normal pipeline for one triangle per word.
// Use: present a triangle on the req_ channel (three corners, packed corner
// indices, last flag) with req_valid; it is taken when req_valid and
// req_ready are both high. One word leaves on the rsp_ channel per triangle,
// in order: the unit normal with NORMAL_FRAC_BITS fraction bits, the indices
// passed through, the degenerate flag and the final flag.
// The pipeline is six front stages for edges, cross product, scaling and sum
// of squares, 32 square root cells (one root bit each), NORMAL_FRAC_BITS + 1
// divider cells (one quotient bit each) and one output register.
// Throughput is one triangle per cycle while the pipeline is not held by
// rsp_ready; every stage is a register row that moves a word each cycle it advances.
// When the receiver holds rsp_ready low with a word waiting, the whole
// pipeline holds and req_ready drops; it resumes as soon as the word goes.
// Synchronous reset empties the pipeline; no clearing pass is needed.
`default_nettype none
module triangle_flat_normal #(
   parameter int COORD_BITS       = tfn_pkg::CoordBitsDef,
   parameter int INDEX_BITS       = tfn_pkg::IndexBitsDef,
   parameter int NORMAL_FRAC_BITS = tfn_pkg::NormFracDef
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic signed [15:0]          req_p0_x,
   input  wire logic signed [15:0]          req_p0_y,
   input  wire logic signed [15:0]          req_p0_z,
   input  wire logic signed [15:0]          req_p1_x,
   input  wire logic signed [15:0]          req_p1_y,
   input  wire logic signed [15:0]          req_p1_z,
   input  wire logic signed [15:0]          req_p2_x,
   input  wire logic signed [15:0]          req_p2_y,
   input  wire logic signed [15:0]          req_p2_z,
   input  wire logic [47:0]                 req_corner_indices,
   input  wire logic                        req_last_triangle,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic signed [15:0]               rsp_normal_x,
   output logic signed [15:0]               rsp_normal_y,
   output logic signed [15:0]               rsp_normal_z,
   output logic [47:0]                      rsp_target_indices,
   output logic                             rsp_degenerate,
   output logic                             rsp_final_flag
);
   localparam int QW    = NORMAL_FRAC_BITS + 1;
   localparam int NSQ   = tfn_pkg::RootW;
   localparam int IW    = (3 * INDEX_BITS < tfn_pkg::IdxW) ? 3 * INDEX_BITS : tfn_pkg::IdxW;
   localparam logic [tfn_pkg::IdxW-1:0] IdxMask =
      tfn_pkg::IdxW'(({(tfn_pkg::IdxW+1){1'b0}} | 1) << IW) - tfn_pkg::IdxW'(1);

   logic                               advance;
   logic [8:0][tfn_pkg::FieldW-1:0]    coords;
   tfn_pkg::side_type                  side_req;

   logic                               sq_v    [NSQ+1];
   logic [tfn_pkg::SumW-1:0]           sq_s    [NSQ+1];
   logic [tfn_pkg::RemW-1:0]           sq_rem  [NSQ+1];
   logic [tfn_pkg::RootW-1:0]          sq_root [NSQ+1];
   tfn_pkg::mag_type                   sq_m    [NSQ+1];
   tfn_pkg::side_type                  sq_side [NSQ+1];

   logic                               dv_v    [QW+1];
   logic [tfn_pkg::RootW-1:0]          dv_len  [QW+1];
   logic [2:0][tfn_pkg::DivRemW-1:0]   dv_r    [QW+1];
   logic [2:0][QW-1:0]                 dv_q    [QW+1];
   tfn_pkg::side_type                  dv_side [QW+1];

   logic                               rsp_valid_ff;
   logic [2:0][15:0]                   normal_ff, normal_in;
   logic [31:0]                        wide [3];
   tfn_pkg::side_type                  rsp_side_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      coords   = {req_p2_z, req_p2_y, req_p2_x, req_p1_z, req_p1_y, req_p1_x,
                  req_p0_z, req_p0_y, req_p0_x};
      side_req       = '0;
      side_req.idx   = req_corner_indices & IdxMask;
      side_req.last  = req_last_triangle;
   end

   tfn_cross #(.CB(COORD_BITS)) u_cross (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid && req_ready),
      .in_p      (coords),
      .in_side   (side_req),
      .out_valid (sq_v[0]),
      .out_s     (sq_s[0]),
      .out_m     (sq_m[0]),
      .out_side  (sq_side[0])
   );

   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;

   for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
      tfn_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (sq_v[g]),
         .in_s      (sq_s[g]),
         .in_rem    (sq_rem[g]),
         .in_root   (sq_root[g]),
         .in_m      (sq_m[g]),
         .in_side   (sq_side[g]),
         .out_valid (sq_v[g+1]),
         .out_s     (sq_s[g+1]),
         .out_rem   (sq_rem[g+1]),
         .out_root  (sq_root[g+1]),
         .out_m     (sq_m[g+1]),
         .out_side  (sq_side[g+1])
      );
   end

   always_comb begin
      dv_v[0]    = sq_v[NSQ];
      dv_len[0]  = sq_root[NSQ];
      dv_side[0] = sq_side[NSQ];
      for (int k = 0; k < 3; k++) begin
         dv_r[0][k] = tfn_pkg::DivRemW'(sq_m[NSQ][k]);
         dv_q[0][k] = '0;
      end
   end

   for (genvar g = 0; g < QW; g++) begin : g_div
      tfn_div_cell #(.QW(QW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (dv_v[g]),
         .in_len    (dv_len[g]),
         .in_r      (dv_r[g]),
         .in_q      (dv_q[g]),
         .in_side   (dv_side[g]),
         .out_valid (dv_v[g+1]),
         .out_len   (dv_len[g+1]),
         .out_r     (dv_r[g+1]),
         .out_q     (dv_q[g+1]),
         .out_side  (dv_side[g+1])
      );
   end

   // apply sign, keep the low 16 bits, zero the normal of a flat triangle
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         wide[k] = dv_side[QW].neg[k] ? -(32'(dv_q[QW][k])) : 32'(dv_q[QW][k]);
         normal_in[k] = dv_side[QW].degen ? 16'd0 : wide[k][15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_v[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         normal_ff   <= normal_in;
         rsp_side_ff <= dv_side[QW];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_normal_x       = normal_ff[0];
   assign rsp_normal_y       = normal_ff[1];
   assign rsp_normal_z       = normal_ff[2];
   assign rsp_target_indices = rsp_side_ff.idx;
   assign rsp_degenerate     = rsp_side_ff.degen;
   assign rsp_final_flag     = rsp_side_ff.last;

   a_degen_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_normal_x == 16'd0 && rsp_normal_y == 16'd0 && rsp_normal_z == 16'd0)
      else $error("flat triangle with nonzero normal");

   a_div_rem : assert property (@(posedge clock) disable iff (reset)
      dv_v[QW] && !dv_side[QW].degen |->
         dv_r[QW][0][tfn_pkg::DivRemW-1:1] < (tfn_pkg::DivRemW-1)'(dv_len[QW]) &&
         dv_r[QW][1][tfn_pkg::DivRemW-1:1] < (tfn_pkg::DivRemW-1)'(dv_len[QW]) &&
         dv_r[QW][2][tfn_pkg::DivRemW-1:1] < (tfn_pkg::DivRemW-1)'(dv_len[QW]))
      else $error("divider remainder not below the length");

   a_tail_move : assert property (@(posedge clock) disable iff (reset)
      advance && dv_v[QW] |=> rsp_valid)
      else $error("finished word lost at the output register");

   a_len_nonzero : assert property (@(posedge clock) disable iff (reset)
      sq_v[NSQ] && !sq_side[NSQ].degen |-> sq_root[NSQ] != '0)
      else $error("zero length for a triangle with area");
endmodule
`default_nettype wire
